[rtl/wcg_pkg.sv]
// shared types and constants of the window coefficient generator
// no dependencies; used by wcg_horner_cell, wcg_cos_unit and the top level
package wcg_pkg;

    // default field scaling
    localparam int POS_FRAC_BITS_DEF  = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // q30 arithmetic
    localparam logic [30:0] Q30_ONE = 31'd1 << 30;

    // pi/2 in q32 is 2^32 + HALF_PI_LO, so the angle multiply is 30x32 plus an add
    localparam logic [31:0] HALF_PI_LO = 32'd2451551556;

    // blackman constants in q30
    localparam logic [28:0] K042_Q30 = 29'd450971566;
    localparam logic [26:0] K008_Q30 = 27'd85899346;

    // horner terms of the cos / sin polynomials
    localparam int HORNER_TERMS = 5;

    // fold, square, two stages per cell, magnitude stage
    localparam int COS_LAT = 3 + 2 * HORNER_TERMS;

    typedef enum logic [1:0] {
        WIN_RECT     = 2'd0,
        WIN_HANN     = 2'd1,
        WIN_BLACKMAN = 2'd2,
        WIN_TRI      = 2'd3
    } window_kind_t;

    // data handed from cell to cell
    typedef struct packed {
        logic [29:0] a;        // folded angle, q30
        logic [29:0] a2;       // angle squared, q30
        logic [30:0] h;        // horner accumulator, q30, at most 1.0
        logic        use_sin;  // octant needs the sine polynomial
        logic        neg;      // result is negated
    } horner_t;

endpackage

[rtl/wcg_horner_cell.sv]
// one horner step h' = 1 - ((a2*h) >> 30) / d, two register stages
// depends on wcg_pkg; d is chosen per item between the cos and sin divisors
module wcg_horner_cell #(
    parameter int DIV_COS = 2,
    parameter int DIV_SIN = 6
) (
    input  logic             aclk,
    input  logic             en,
    input  wcg_pkg::horner_t cell_in,
    output wcg_pkg::horner_t cell_out
);

    // exact division by reciprocal: m = ceil(2^(30+l)/d) for a 30-bit numerator
    localparam int L_COS = $clog2(DIV_COS);
    localparam int L_SIN = $clog2(DIV_SIN);
    localparam logic [30:0] M_COS =
        31'(((64'd1 << (30 + L_COS)) + 64'(DIV_COS) - 64'd1) / 64'(DIV_COS));
    localparam logic [30:0] M_SIN =
        31'(((64'd1 << (30 + L_SIN)) + 64'(DIV_SIN) - 64'd1) / 64'(DIV_SIN));

    wcg_pkg::horner_t mid_reg;
    logic [29:0]      p_reg;
    logic [60:0]      ph_prod;
    logic [60:0]      pm_prod;
    logic [29:0]      quot;
    wcg_pkg::horner_t out_next;
    wcg_pkg::horner_t out_reg;

    // stage 1: product of the square and the accumulator
    assign ph_prod = 61'(cell_in.a2) * 61'(cell_in.h);

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg <= cell_in;
            p_reg   <= ph_prod[59:30];
        end
    end

    // stage 2: reciprocal multiply and subtract from one
    always_comb begin
        pm_prod = mid_reg.use_sin ? 61'(p_reg) * 61'(M_SIN) : 61'(p_reg) * 61'(M_COS);
        quot    = mid_reg.use_sin ? 30'(pm_prod >> (30 + L_SIN))
                                  : 30'(pm_prod >> (30 + L_COS));
        out_next   = mid_reg;
        out_next.h = wcg_pkg::Q30_ONE - {1'b0, quot};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign cell_out = out_reg;

endmodule

[rtl/wcg_cos_unit.sv]
// cos(2*pi*turn/2^32) in signed q30: octant fold, square, chain of horner cells
// depends on wcg_pkg and wcg_horner_cell
module wcg_cos_unit (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        turn,
    output logic signed [31:0] cos_q30
);

    logic [1:0]  quad;
    logic [29:0] rem;
    logic        fold;
    logic [29:0] rem_f;
    logic [61:0] ang_prod;
    logic [29:0] ang;

    logic [29:0] a_reg;
    logic        use_sin_a_reg;
    logic        neg_a_reg;
    logic [59:0] sq_prod;

    wcg_pkg::horner_t link [0:wcg_pkg::HORNER_TERMS];
    wcg_pkg::horner_t sq_reg;

    logic [60:0] fin_prod;
    logic [30:0] mag;
    logic signed [31:0] cos_reg;

    // fold into the first octant of the quadrant
    always_comb begin
        quad     = turn[31:30];
        rem      = turn[29:0];
        fold     = rem > 30'(31'd1 << 29);
        rem_f    = fold ? 30'(31'd1 << 30) - rem : rem;
        ang_prod = 62'(rem_f) * 62'(wcg_pkg::HALF_PI_LO);
        ang      = rem_f + ang_prod[61:32];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg         <= ang;
            use_sin_a_reg <= fold ^ quad[0];
            neg_a_reg     <= quad[1] ^ quad[0];
        end
    end

    assign sq_prod = 60'(a_reg) * 60'(a_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg.a       <= a_reg;
            sq_reg.a2      <= sq_prod[59:30];
            sq_reg.h       <= wcg_pkg::Q30_ONE;
            sq_reg.use_sin <= use_sin_a_reg;
            sq_reg.neg     <= neg_a_reg;
        end
    end

    assign link[0] = sq_reg;

    for (genvar k = 0; k < wcg_pkg::HORNER_TERMS; k++) begin : g_cell
        localparam int N = wcg_pkg::HORNER_TERMS - k;
        wcg_horner_cell #(
            .DIV_COS((2 * N) * (2 * N - 1)),
            .DIV_SIN((2 * N) * (2 * N + 1))
        ) u_cell (
            .aclk    (aclk),
            .en      (en),
            .cell_in (link[k]),
            .cell_out(link[k + 1])
        );
    end

    // sine needs one more multiply by the angle
    assign fin_prod = 61'(link[wcg_pkg::HORNER_TERMS].a) * 61'(link[wcg_pkg::HORNER_TERMS].h);
    assign mag      = link[wcg_pkg::HORNER_TERMS].use_sin ? {1'b0, fin_prod[59:30]}
                                                          : link[wcg_pkg::HORNER_TERMS].h;

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= link[wcg_pkg::HORNER_TERMS].neg ? 32'sd0 - $signed({1'b0, mag})
                                                       : $signed({1'b0, mag});
        end
    end

    assign cos_q30 = cos_reg;

endmodule

[rtl/window_coefficient_generator.sv]
// top level of the window coefficient generator: rectangular, hann, blackman, triangular
// depends on wcg_pkg and wcg_cos_unit (which uses wcg_horner_cell)
//
// usage:
//   s_ channel: one item per position x = position / 2^POS_FRAC_BITS, saturated to 1.0
//   m_ channel: one item per position, the window weight, 2^COEF_FRAC_BITS means 1.0
//   cfg channel: writes the window kind (0 rect, 1 hann, 2 blackman, 3 triangular);
//   cfg_ready is high whenever aresetn is high, write it only while no item is in flight
// throughput: one item per cycle while the skid register is free; the rate is set by the
//   chain of horner cells, each of which holds one item per register stage
// path: the accepting edge loads the input register, then the item passes the cosine
//   units, the blackman product register, the weight and rounding register and the
//   output register, which drives m_tvalid
// reset: aresetn low clears all valid flags and sets the kind to rectangular, and
//   holds s_tready and cfg_ready low; no memories, so the block takes items as soon
//   as aresetn is high again
// stall: a held-back item sits in the output register and one more in a skid
//   register; the pipeline keeps taking items until the skid register fills, and
//   s_tready then drops until m_tready returns
module window_coefficient_generator #(
    parameter int POS_FRAC_BITS  = wcg_pkg::POS_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS = wcg_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // input items
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((POS_FRAC_BITS + 8) / 8) * 8 - 1:0] s_tdata,   // position

    // result items
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [((COEF_FRAC_BITS + 8) / 8) * 8 - 1:0] m_tdata,  // coefficient

    // window kind register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int POS_W      = POS_FRAC_BITS + 1;
    localparam int COEF_W     = COEF_FRAC_BITS + 1;
    localparam int M_BYTES_W  = ((COEF_FRAC_BITS + 8) / 8) * 8;
    localparam int DEPTH      = wcg_pkg::COS_LAT + 3;   // vld stages 0..DEPTH-1
    localparam int X_DEPTH    = wcg_pkg::COS_LAT + 2;   // x needed up to the weight stage
    localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1) << POS_FRAC_BITS;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic signed [63:0] ONE60   = 64'sd1 <<< 60;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (59 - COEF_FRAC_BITS);

    // window kind register
    wcg_pkg::window_kind_t kind_reg;

    // pipeline control and position line
    logic             en;
    logic             vld_reg [0:DEPTH-1];
    logic [POS_W-1:0] x_reg   [0:X_DEPTH-1];
    logic [POS_W-1:0] pos_in;
    logic [POS_W-1:0] pos_sat;

    // cosine datapath
    logic [32:0]        turn_wide;
    logic [31:0]        turn1;
    logic [31:0]        turn2;
    logic signed [31:0] c1;
    logic signed [31:0] c2;

    // blackman product stage
    logic signed [31:0] c1_reg;
    logic signed [59:0] prod2_next;
    logic signed [59:0] prod2_reg;

    // weight stage
    logic [POS_W-1:0]   x_w;
    logic [POS_W:0]     twox;
    logic [POS_W:0]     tri_dist;
    logic [POS_W-1:0]   tri_t;
    logic signed [63:0] c1_ext;
    logic signed [63:0] w60;
    logic signed [63:0] w60_clamp;
    logic signed [63:0] round_sum;
    logic [COEF_W-1:0]  coef_next;
    logic [COEF_W-1:0]  coef_reg;

    // output register and skid
    logic              out_free;
    logic              m_tvalid_reg;
    logic [COEF_W-1:0] out_data_reg;
    logic              skid_vld_reg;
    logic [COEF_W-1:0] skid_data_reg;

    // config write, accepted whenever out of reset
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= wcg_pkg::WIN_RECT;
        end else if (cfg_valid) begin
            kind_reg <= wcg_pkg::window_kind_t'(cfg_data);
        end
    end

    // the whole pipeline moves while the skid register is free
    assign en       = !skid_vld_reg;
    assign s_tready = en && aresetn;

    // saturate the position to 1.0
    assign pos_in  = s_tdata[POS_W-1:0];
    assign pos_sat = (pos_in > POS_ONE) ? POS_ONE : pos_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= pos_sat;
            for (int i = 1; i < X_DEPTH; i++) begin
                x_reg[i] <= x_reg[i-1];
            end
        end
    end

    // phase as a 32-bit turn fraction; 1.0 wraps to zero
    assign turn_wide = 33'(x_reg[0]) << (32 - POS_FRAC_BITS);
    assign turn1     = turn_wide[31:0];
    assign turn2     = {turn1[30:0], 1'b0};

    wcg_cos_unit u_cos1 (
        .aclk   (aclk),
        .en     (en),
        .turn   (turn1),
        .cos_q30(c1)
    );

    wcg_cos_unit u_cos2 (
        .aclk   (aclk),
        .en     (en),
        .turn   (turn2),
        .cos_q30(c2)
    );

    // 0.08 * cos(4 pi x), registered before the sum
    assign prod2_next = 60'($signed({1'b0, wcg_pkg::K008_Q30})) * 60'(c2);

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= c1;
            prod2_reg <= prod2_next;
        end
    end

    // weight in q60, clamp to [0, 1.0], round half up
    always_comb begin
        x_w      = x_reg[X_DEPTH-1];
        twox     = {x_w, 1'b0};
        tri_dist = (twox >= (POS_W+1)'(POS_ONE)) ? twox - (POS_W+1)'(POS_ONE)
                                                 : (POS_W+1)'(POS_ONE) - twox;
        tri_t    = (tri_dist > (POS_W+1)'(POS_ONE)) ? '0
                                                    : POS_ONE - tri_dist[POS_W-1:0];
        c1_ext   = {{32{c1_reg[31]}}, c1_reg};
        unique case (kind_reg)
            wcg_pkg::WIN_HANN: begin
                w60 = ((64'sd1 <<< 30) - c1_ext) <<< 29;
            end
            wcg_pkg::WIN_BLACKMAN: begin
                w60 = ($signed(64'(wcg_pkg::K042_Q30)) <<< 30) - (c1_ext <<< 29)
                      + {{4{prod2_reg[59]}}, prod2_reg};
            end
            wcg_pkg::WIN_TRI: begin
                w60 = $signed(64'(tri_t)) <<< (60 - POS_FRAC_BITS);
            end
            wcg_pkg::WIN_RECT: begin
                w60 = ONE60;
            end
            default: begin
                w60 = ONE60;
            end
        endcase
        if (w60 < 64'sd0) begin
            w60_clamp = 64'sd0;
        end else if (w60 > ONE60) begin
            w60_clamp = ONE60;
        end else begin
            w60_clamp = w60;
        end
        round_sum = w60_clamp + HALF_LSB;
        coef_next = round_sum[60:60-COEF_FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coef_reg <= coef_next;
        end
    end

    // output register with one skid entry behind it
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
                out_data_reg <= skid_data_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (out_free) begin
            m_tvalid_reg <= vld_reg[DEPTH-1];
            out_data_reg <= coef_reg;
        end else if (vld_reg[DEPTH-1]) begin
            skid_vld_reg  <= 1'b1;
            skid_data_reg <= coef_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_BYTES_W'(out_data_reg);

    // skid holds an item only behind a held output item
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid item without output item");

    // skid fills only when the output item was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid filled without a stall");

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item lost at the input stage");

    // weight never exceeds 1.0
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_data_reg <= COEF_ONE))
        else $error("coefficient above 1.0");

endmodule
